### hw/rtl/sobel_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package sobel_pkg;

    // Line store depth and the largest frame height in use.
    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 4096;

    localparam int PIX_W       = 8;
    localparam int WIDTH_REG_W = 10;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 13;

    typedef logic [PIX_W-1:0]        t_pixel;
    typedef logic [CFG_INDEX_W-1:0]  t_cfg_index;
    typedef logic [CFG_DATA_W-1:0]   t_cfg_data;
    typedef logic [WIDTH_REG_W-1:0]  t_width;
    typedef logic [HEIGHT_REG_W-1:0] t_height;

    // Configuration register indexes.
    localparam t_cfg_index REG_IMAGE_WIDTH  = 4'd0;
    localparam t_cfg_index REG_IMAGE_HEIGHT = 4'd1;

    localparam t_width  IMAGE_WIDTH_RESET  = 10'd512;
    localparam t_height IMAGE_HEIGHT_RESET = 13'd512;

    localparam t_pixel MAG_MAX = 8'd255;

endpackage
`default_nettype wire

### hw/rtl/sobel_if.sv
`timescale 1ns / 1ps
`default_nettype none
interface sobel_pix_if;
    import sobel_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel pixel;
    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sobel_mag_if;
    import sobel_pkg::*;
    logic   valid;
    logic   ready;
    t_pixel edge_magnitude;
    modport source (output valid, output edge_magnitude, input ready);
    modport sink   (input valid, input edge_magnitude, output ready);
endinterface

interface sobel_cfg_if;
    import sobel_pkg::*;
    logic       valid;
    logic       ready;
    t_cfg_index index;
    t_cfg_data  data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/sobel_edge_stream_3x3_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Streaming 3x3 Sobel edge detector. Grey pixels enter on i_pix in raster order, one
// request per pixel. Once one line plus one pixel has been taken in, every further pixel
// produces one request on o_mag carrying |Gx|+|Gy| of the window centre, saturated to 255,
// and 0 when that centre lies on the frame border. Row and column tracking wraps at the
// end of each frame; the start-up fill runs once after reset and again only if the width
// is raised beyond what has been filled, so later frames follow without a gap. i_cfg
// writes image_width (index 0) and image_height (index 1); it is always ready and must
// be used only while the pipeline is empty. Throughput is one pixel per clock while o_mag
// takes results: the two line stores share one 16-bit memory whose read happens on
// acceptance and whose write-back follows when that pixel leaves the first stage, so
// consecutive pixels touch different entries. A result passes the memory read, gradient
// stage and magnitude register in turn before it is offered on o_mag.
// When o_mag stalls, the three stages hold and i_pix.ready drops once they are full.
// Reset is synchronous: both registers return to 512 and all counters clear. The line
// memory is not swept; a high-water mark of written entries makes unwritten entries
// read as zero, so the block takes pixels from the first cycle after reset.
module sobel_edge_stream_3x3_top
    import sobel_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    sobel_cfg_if.sink   i_cfg,
    sobel_pix_if.sink   i_pix,
    sobel_mag_if.source o_mag
);

    localparam int POS_W = $clog2(MAX_WIDTH);
    localparam int HW_W  = POS_W + 1;
    localparam int ROW_W = $clog2(MAX_HEIGHT);

    // Configuration registers and their clamped values.
    t_width  r_image_width;
    t_height r_image_height;
    t_width  w_use;
    t_width  w_last;
    t_width  w_m2;
    t_height h_use;
    t_height h_last;
    t_height h_m2;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RESET;
            r_image_height <= IMAGE_HEIGHT_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_IMAGE_WIDTH: begin
                    r_image_width <= i_cfg.data[WIDTH_REG_W-1:0];
                end
                REG_IMAGE_HEIGHT: begin
                    r_image_height <= i_cfg.data[HEIGHT_REG_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_image_width < WIDTH_REG_W'(3)) begin
            w_use = WIDTH_REG_W'(3);
        end else if (r_image_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            w_use = WIDTH_REG_W'(MAX_WIDTH);
        end else begin
            w_use = r_image_width;
        end
        if (r_image_height < HEIGHT_REG_W'(3)) begin
            h_use = HEIGHT_REG_W'(3);
        end else if (r_image_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            h_use = HEIGHT_REG_W'(MAX_HEIGHT);
        end else begin
            h_use = r_image_height;
        end
        w_last = w_use - WIDTH_REG_W'(1);
        w_m2   = w_use - WIDTH_REG_W'(2);
        h_last = h_use - HEIGHT_REG_W'(1);
        h_m2   = h_use - HEIGHT_REG_W'(2);
    end

    // Pipeline handshake. Each stage moves when the one after it is empty or moving.
    logic in_accept;
    logic s1_fire;
    logic s2_move;
    logic r_s1_valid;
    logic r_s2_valid;
    logic r_out_valid;

    assign s2_move        = r_s2_valid && (!r_out_valid || o_mag.ready);
    assign s1_fire        = r_s1_valid && (!r_s2_valid || s2_move);
    assign i_pix.ready    = !r_s1_valid || s1_fire;
    assign in_accept      = i_pix.valid && i_pix.ready;

    // Line position: address of the memory read issued on acceptance.
    logic [POS_W-1:0] r_pos;
    logic [POS_W-1:0] n_pos;

    always_comb begin
        if ({1'b0, r_pos} >= w_last) begin
            n_pos = '0;
        end else begin
            n_pos = r_pos + POS_W'(1);
        end
    end

    // Both line stores in one memory: upper byte two lines ago, lower byte last line.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;
    logic [POS_W-1:0]   r_s1_pos;
    t_pixel             r_s1_px;
    logic [HW_W-1:0]    r_hw;
    logic               s1_seen;
    t_pixel             s1_up;
    t_pixel             s1_lo;

    // Entries at or above the high-water mark were never written and read as zero.
    // Addresses only step up by one or return to zero, so the written set is a prefix.
    assign s1_seen = {1'b0, r_s1_pos} < r_hw;
    assign s1_up   = s1_seen ? r_rd_data[2*PIX_W-1:PIX_W] : '0;
    assign s1_lo   = s1_seen ? r_rd_data[PIX_W-1:0] : '0;

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_rd_data <= line_mem[r_pos];
        end
        if (s1_fire) begin
            line_mem[r_s1_pos] <= {s1_lo, r_s1_px};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
            r_hw       <= '0;
        end else begin
            if (in_accept) begin
                r_pos      <= n_pos;
                r_s1_valid <= 1'b1;
            end else if (s1_fire) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_fire && !s1_seen) begin
                r_hw <= {1'b0, r_s1_pos} + HW_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_pos <= r_pos;
            r_s1_px  <= i_pix.pixel;
        end
    end

    // Window: row 0 holds the oldest line, column 0 the oldest column.
    t_pixel r_win [9];
    t_pixel n_win [9];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_win[k*3+0] = r_win[k*3+1];
            n_win[k*3+1] = r_win[k*3+2];
        end
        n_win[2] = s1_up;
        n_win[5] = s1_lo;
        n_win[8] = r_s1_px;
    end

    // Gradients of the shifted window, formed as differences of positive sums.
    logic [PIX_W+1:0] gx_pos;
    logic [PIX_W+1:0] gx_neg;
    logic [PIX_W+1:0] gy_pos;
    logic [PIX_W+1:0] gy_neg;
    logic [PIX_W+2:0] s1_gx;
    logic [PIX_W+2:0] s1_gy;

    always_comb begin
        gx_pos = {2'b00, n_win[2]} + {1'b0, n_win[5], 1'b0} + {2'b00, n_win[8]};
        gx_neg = {2'b00, n_win[0]} + {1'b0, n_win[3], 1'b0} + {2'b00, n_win[6]};
        gy_pos = {2'b00, n_win[0]} + {1'b0, n_win[1], 1'b0} + {2'b00, n_win[2]};
        gy_neg = {2'b00, n_win[6]} + {1'b0, n_win[7], 1'b0} + {2'b00, n_win[8]};
        s1_gx  = {1'b0, gx_pos} - {1'b0, gx_neg};
        s1_gy  = {1'b0, gy_pos} - {1'b0, gy_neg};
    end

    // Start-up fill and output position tracking.
    logic [HW_W-1:0]  r_fill;
    logic [ROW_W-1:0] r_row;
    logic [POS_W-1:0] r_col;
    logic             s1_result;
    logic             s1_border;

    assign s1_result = r_fill > w_use;
    assign s1_border = (r_row == '0) || ({1'b0, r_row} > h_m2)
                    || (r_col == '0) || ({1'b0, r_col} > w_m2);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
            r_fill <= '0;
            r_row  <= '0;
            r_col  <= '0;
        end else if (s1_fire) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= n_win[k];
            end
            if (!s1_result) begin
                r_fill <= r_fill + HW_W'(1);
            end else if ({1'b0, r_col} < w_last) begin
                r_col <= r_col + POS_W'(1);
            end else if ({1'b0, r_row} >= h_last) begin
                r_row <= '0;
                r_col <= '0;
            end else begin
                r_row <= r_row + ROW_W'(1);
                r_col <= '0;
            end
        end
    end

    // Gradient stage.
    logic [PIX_W+2:0] r_s2_gx;
    logic [PIX_W+2:0] r_s2_gy;
    logic             r_s2_border;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s1_fire && s1_result) begin
            r_s2_valid <= 1'b1;
        end else if (s2_move) begin
            r_s2_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_fire && s1_result) begin
            r_s2_gx     <= s1_gx;
            r_s2_gy     <= s1_gy;
            r_s2_border <= s1_border;
        end
    end

    // Magnitude, saturation and border suppression into the output register.
    logic [PIX_W+1:0] abs_gx;
    logic [PIX_W+1:0] abs_gy;
    logic [PIX_W+2:0] mag_sum;
    t_pixel           n_mag;
    t_pixel           r_mag;

    always_comb begin
        abs_gx  = r_s2_gx[PIX_W+2] ? (PIX_W+2)'(0) - r_s2_gx[PIX_W+1:0] : r_s2_gx[PIX_W+1:0];
        abs_gy  = r_s2_gy[PIX_W+2] ? (PIX_W+2)'(0) - r_s2_gy[PIX_W+1:0] : r_s2_gy[PIX_W+1:0];
        mag_sum = {1'b0, abs_gx} + {1'b0, abs_gy};
        if (r_s2_border) begin
            n_mag = '0;
        end else if (mag_sum > (PIX_W+3)'(MAG_MAX)) begin
            n_mag = MAG_MAX;
        end else begin
            n_mag = mag_sum[PIX_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s2_move) begin
            r_out_valid <= 1'b1;
        end else if (o_mag.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_move) begin
            r_mag <= n_mag;
        end
    end

    assign o_mag.valid          = r_out_valid;
    assign o_mag.edge_magnitude = r_mag;

`ifndef SYNTHESIS
    // The write-back of one pixel never lands on the entry read for the next one.
    a_no_rw_clash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && in_accept) |-> (r_s1_pos != r_pos))
        else $error("line memory read and write hit the same entry");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= HW_W'(MAX_WIDTH))
        else $error("high-water mark beyond the line memory");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= HW_W'(MAX_WIDTH + 1))
        else $error("start-up fill counter ran past its limit");

    a_fill_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_fill >= $past(r_fill)))
        else $error("start-up fill counter went backwards");
`endif

endmodule
`default_nettype wire

### tb/sobel_edge_stream_3x3_top_test.sv
`timescale 1ns / 1ps
// Testbench for the streaming 3x3 Sobel edge detector.
//
// Pixels go in through the pixel request channel and edge magnitudes come back
// on the magnitude channel. A software copy of the line stores, window and
// position counters runs beside the block. Every accepted pixel is pushed through
// that copy, and any magnitude it yields goes to the back of a queue. The result
// checker takes the oldest queued value for every magnitude request that the
// block completes and compares the two.
module sobel_edge_stream_3x3_top_test;
    import sobel_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int CYCLE_LIMIT  = 200_000;
    // Three pipeline stages plus margin. Pixels consumed by the start-up fill
    // produce nothing, so an empty queue alone does not mean the block is idle.
    localparam int PIPE_SETTLE  = 8;
    localparam int HOLD_OFF_LEN = 120;

    // Register indexes that the block does not implement and must ignore.
    localparam t_cfg_index REG_UNUSED_LOW = 4'd2;
    localparam t_cfg_index REG_UNUSED_TOP = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sobel_cfg_if cfg_bus ();
    sobel_pix_if pix_bus ();
    sobel_mag_if mag_bus ();

    sobel_edge_stream_3x3_top i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg_bus),
        .i_pix   (pix_bus),
        .o_mag   (mag_bus)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Shared controls. When idling is on, both the pixel sender and the result
    // receiver insert random bursts of dead cycles.
    bit idling_on;
    int hold_off_request;
    int mismatch_count;
    int cycle_count;

    // Magnitudes still owed by the block, oldest first.
    t_pixel expected_edges[$];

    // Software copy of the block's state and registers.
    t_width  width_reg;
    t_height height_reg;
    t_pixel  upper_line [MAX_WIDTH];
    t_pixel  lower_line [MAX_WIDTH];
    t_pixel  window [9];
    int      line_pos;
    int      row_cnt;
    int      col_cnt;
    int      fill_cnt;

    // Advance the software copy by one pixel and queue the magnitude it gives, if any.
    task automatic predict_magnitude(input t_pixel px);
        int     w;
        int     h;
        int     pos;
        int     p [9];
        int     gx;
        int     gy;
        int     sum;
        bit     on_border;
        t_pixel upper_px;
        t_pixel lower_px;

        // Out-of-range register values are clamped to what the hardware supports.
        w = (width_reg < 3) ? 3 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg));
        h = (height_reg < 3) ? 3 : ((height_reg > MAX_HEIGHT) ? MAX_HEIGHT : int'(height_reg));
        pos = (line_pos >= MAX_WIDTH) ? 0 : line_pos;

        // Shift the window one column left and bring in the new right column,
        // oldest line on top and the incoming pixel at the bottom.
        for (int k = 0; k < 3; k++) begin
            window[k * 3 + 0] = window[k * 3 + 1];
            window[k * 3 + 1] = window[k * 3 + 2];
        end
        upper_px = upper_line[pos];
        lower_px = lower_line[pos];
        window[2] = upper_px;
        window[5] = lower_px;
        window[8] = px;
        upper_line[pos] = lower_px;
        lower_line[pos] = px;
        // A width shrunk mid-stream makes any position past the new end wrap at once.
        line_pos = (pos >= w - 1) ? 0 : pos + 1;

        // The start-up fill runs once after reset. It resumes only if the width
        // is later raised beyond what has been filled.
        if (fill_cnt <= w) begin
            fill_cnt++;
            return;
        end

        on_border = (row_cnt < 1) || (row_cnt > h - 2) || (col_cnt < 1) || (col_cnt > w - 2);
        for (int k = 0; k < 9; k++) begin
            p[k] = int'(window[k]);
        end
        gx = (p[2] + 2 * p[5] + p[8]) - (p[0] + 2 * p[3] + p[6]);
        gy = (p[0] + 2 * p[1] + p[2]) - (p[6] + 2 * p[7] + p[8]);
        sum = ((gx < 0) ? -gx : gx) + ((gy < 0) ? -gy : gy);
        if (sum > int'(MAG_MAX)) begin
            sum = int'(MAG_MAX);
        end
        expected_edges.push_back(on_border ? t_pixel'(0) : t_pixel'(sum));

        // Output position tracking. Positions past a newly shrunk end wrap as if
        // they had just reached it.
        if (col_cnt < w - 1) begin
            col_cnt++;
        end else if (row_cnt >= h - 1) begin
            row_cnt = 0;
            col_cnt = 0;
        end else begin
            row_cnt++;
            col_cnt = 0;
        end
    endtask

    // Write one register. It is called only while the pipeline is empty. The extra
    // falling edge at the end keeps a following write from lowering and raising
    // valid in the same time step.
    task automatic write_reg(input t_cfg_index idx, input t_cfg_data value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
        case (idx)
            REG_IMAGE_WIDTH: begin
                width_reg = value[WIDTH_REG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
                height_reg = value[HEIGHT_REG_W-1:0];
            end
            default: begin
            end
        endcase
        @(negedge i_clk);
    endtask

    // Offer one pixel request, possibly after an idle burst, and wait until the block
    // takes it. Valid stays high afterwards, so back-to-back pixels never see a
    // glitch. The prediction runs on the falling edge after acceptance, which keeps
    // it away from the rising edge where the checker pops the queue.
    task automatic send_pixel(input t_pixel px);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            pix_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.pixel <= px;
        @(posedge i_clk);
        while (!pix_bus.ready) @(posedge i_clk);
        @(negedge i_clk);
        predict_magnitude(px);
    endtask

    // Stop offering, let every owed magnitude arrive, then let the pipeline settle.
    // Pixels still in the start-up fill owe nothing, hence the fixed tail.
    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        while (expected_edges.size() != 0) @(negedge i_clk);
        repeat (PIPE_SETTLE) @(negedge i_clk);
    endtask

    // Reset values are left untouched here. The fill must last exactly
    // 512 + 1 pixels before the first magnitude, which is still on the top border.
    task automatic test_startup_fill();
        for (int i = 0; i < 520; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
        wait_idle();
    endtask

    // Smallest frame, so that only one window position per frame lies off the border.
    // It is fed with flat black, flat white and a hard vertical edge, which
    // saturates the sum. Writes to unimplemented indexes go in between and must
    // change nothing.
    task automatic test_directed_extremes();
        write_reg(REG_IMAGE_WIDTH, t_cfg_data'(3));
        write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(3));
        for (int i = 0; i < 9; i++) begin
            send_pixel(8'd0);
        end
        for (int i = 0; i < 9; i++) begin
            send_pixel(MAG_MAX);
        end
        wait_idle();
        write_reg(REG_UNUSED_LOW, '1);
        write_reg(REG_UNUSED_TOP, '0);
        for (int i = 0; i < 9; i++) begin
            send_pixel((i % 3 == 2) ? MAG_MAX : 8'd0);
        end
        wait_idle();
    endtask

    // Register values outside the supported range must clamp. Bits above the
    // width field must be dropped.
    task automatic test_register_clamps();
        write_reg(REG_IMAGE_WIDTH, t_cfg_data'(0));
        write_reg(REG_IMAGE_HEIGHT, '1);
        for (int i = 0; i < 20; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
        wait_idle();
        // All ones masks to a width of 1023, which clamps to the full line store.
        write_reg(REG_IMAGE_WIDTH, '1);
        write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(0));
        for (int i = 0; i < 40; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, t_cfg_data'(2));
        write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(2));
        for (int i = 0; i < 12; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
        wait_idle();
    endtask

    // Random frame geometries, mostly small so that rows and frames wrap often,
    // with random content styles. Stream state carries over between phases, so
    // every geometry change also exercises the mid-stream wrap rules.
    task automatic test_random_frames();
        int     sent;
        int     count;
        int     style;
        int     w_pick;
        int     h_pick;
        t_pixel px;

        sent = 0;
        px = '0;
        while (sent < 420) begin
            idling_on = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 7))
                0: w_pick = $urandom_range(0, 2);
                1: w_pick = $urandom_range(200, 1023);
                default: w_pick = $urandom_range(3, 24);
            endcase
            case ($urandom_range(0, 7))
                0: h_pick = $urandom_range(0, 2);
                1: h_pick = $urandom_range(4000, 8191);
                default: h_pick = $urandom_range(3, 10);
            endcase
            // The upper data bits are random, too: the width register must ignore them.
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_IMAGE_WIDTH,
                          {t_cfg_data'($urandom_range(0, 7)) << WIDTH_REG_W} | t_cfg_data'(w_pick));
            end
            if ($urandom_range(0, 3) != 0) begin
                write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(h_pick));
            end
            if ($urandom_range(0, 5) == 0) begin
                write_reg(t_cfg_index'($urandom_range(REG_UNUSED_LOW, REG_UNUSED_TOP)),
                          t_cfg_data'($urandom()));
            end
            style = $urandom_range(0, 3);
            count = $urandom_range(8, 70);
            for (int i = 0; i < count; i++) begin
                // Dim content keeps sums below saturation. Two-level content hits
                // the extremes, and a slow ramp gives small gradients.
                case (style)
                    0: px = t_pixel'($urandom());
                    1: px = t_pixel'($urandom_range(0, 31));
                    2: px = ($urandom_range(0, 1) != 0) ? MAG_MAX : 8'd0;
                    default: px = px + t_pixel'($urandom_range(0, 6));
                endcase
                send_pixel(px);
            end
            sent += count;
            wait_idle();
        end
        idling_on = 1'b1;
    endtask

    // The receiver holds off for a long stretch while pixels keep being offered.
    // The three stages fill, and the block must stall its input without
    // losing or repeating anything.
    task automatic test_output_hold();
        write_reg(REG_IMAGE_WIDTH, t_cfg_data'(7));
        write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(5));
        hold_off_request = HOLD_OFF_LEN;
        for (int i = 0; i < 40; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
        wait_idle();
    endtask

    // The last stretch runs at full rate on both sides.
    task automatic test_full_rate();
        idling_on = 1'b0;
        write_reg(REG_IMAGE_WIDTH, t_cfg_data'(9));
        write_reg(REG_IMAGE_HEIGHT, t_cfg_data'(6));
        for (int i = 0; i < 80; i++) begin
            send_pixel(t_pixel'($urandom()));
        end
    endtask

    // Result receiver. The ready level is decided once per falling edge. A pending
    // hold-off request takes priority over the random idle bursts and is counted
    // out here.
    initial begin : mag_receiver
        int stall_left;

        stall_left = 0;
        mag_bus.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left == 0) begin
                if (hold_off_request != 0) begin
                    stall_left = hold_off_request;
                    hold_off_request = 0;
                end else if (idling_on && $urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 10);
                end
            end
            if (stall_left != 0) begin
                mag_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                mag_bus.ready <= 1'b1;
            end
        end
    end

    // Result checker: every completed magnitude request must match the oldest
    // prediction still waiting.
    always @(posedge i_clk) begin
        t_pixel want;

        if (i_rst_n && mag_bus.valid && mag_bus.ready) begin
            if (expected_edges.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected edge magnitude, expected none, actual %0d",
                         $time, mag_bus.edge_magnitude);
            end else begin
                want = expected_edges.pop_front();
                if (mag_bus.edge_magnitude !== want) begin
                    mismatch_count++;
                    $display("%0t: edge magnitude mismatch, expected %0d, actual %0d",
                             $time, want, mag_bus.edge_magnitude);
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout after %0d cycles, %0d magnitudes still expected",
                 $time, cycle_count, expected_edges.size());
        $display("** sobel_edge_stream_3x3_top: FAILED **");
        $finish;
    end

    initial begin : main_sequence
        // Drive every input to a known level, and clear the software copy to
        // the block's reset state.
        i_rst_n = 1'b0;
        pix_bus.valid = 1'b0;
        pix_bus.pixel = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_IMAGE_WIDTH;
        cfg_bus.data = '0;
        idling_on = 1'b1;
        hold_off_request = 0;
        mismatch_count = 0;
        width_reg = IMAGE_WIDTH_RESET;
        height_reg = IMAGE_HEIGHT_RESET;
        for (int i = 0; i < MAX_WIDTH; i++) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
        end
        for (int i = 0; i < 9; i++) begin
            window[i] = '0;
        end
        line_pos = 0;
        row_cnt = 0;
        col_cnt = 0;
        fill_cnt = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_startup_fill();
        test_directed_extremes();
        test_register_clamps();
        test_random_frames();
        test_output_hold();
        test_full_rate();
        wait_idle();

        if (mismatch_count == 0) begin
            $display("** sobel_edge_stream_3x3_top: PASSED **");
        end else begin
            $display("** sobel_edge_stream_3x3_top: FAILED **");
        end
        $finish;
    end

endmodule

### sim.f
hw/rtl/sobel_pkg.sv
hw/rtl/sobel_if.sv
hw/rtl/sobel_edge_stream_3x3_top.sv
tb/sobel_edge_stream_3x3_top_test.sv
